[rtl/core/mmq_pkg.sv]
// Shared types, field widths and default sizes for the mailbox queue manager.
package mmq_pkg;

    localparam int NUM_MAILBOXES_DEF = 16;
    localparam int MAX_DEPTH_DEF     = 64;
    localparam int DATA_WIDTH_DEF    = 32;

    localparam int CMD_W     = 3;
    localparam int ID_W      = 8;
    localparam int CAP_IN_W  = 10;
    localparam int WORD_W    = 32;
    localparam int STATUS_W  = 3;
    localparam int OCC_W     = 7;
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 56;

    typedef enum logic [CMD_W-1:0] {
        CMD_CREATE  = 3'd0,
        CMD_DESTROY = 3'd1,
        CMD_SEND    = 3'd2,
        CMD_RECEIVE = 3'd3,
        CMD_COUNT   = 3'd4
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_BAD_ID  = 3'd1,
        ST_FULL    = 3'd2,
        ST_EMPTY   = 3'd3,
        ST_NO_BOX  = 3'd4,
        ST_BAD_CAP = 3'd5
    } status_t;

endpackage

[rtl/core/mmq_slot_ram.sv]
// Slot store: one write port and one registered read port.
module mmq_slot_ram #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10,
    parameter int DATA_W = 32
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        // The read register holds its word until the next read is issued.
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/core/multi_mailbox_queue_manager.sv]
// Top level of the mailbox queue manager: command decode, per-mailbox ring state and result stage.
//
// The block takes one command beat per cycle while the result output is not stalled, and returns
// exactly one result beat for each, in order. A command passes through the input register, where
// the mailbox state is read and updated, and then the result register, which lines up with the
// registered read port of the slot store. The slot store holds
// NUM_MAILBOXES * MAX_DEPTH words with one write and one read port, and each mailbox owns its
// own region of MAX_DEPTH words in it. Mailbox state is fully cleared by reset, so no warm-up
// is needed; stored words are only ever read after they were written.
module multi_mailbox_queue_manager
    import mmq_pkg::*;
#(
    parameter int NUM_MAILBOXES = NUM_MAILBOXES_DEF,
    parameter int MAX_DEPTH     = MAX_DEPTH_DEF,
    parameter int DATA_WIDTH    = DATA_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // cmd[2:0], mailbox_id[10:3], capacity[20:11], write_data[52:21], zero[55:53]
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // status[2:0], created_id[10:3], read_data[42:11], occupancy[49:43], zero[55:50]
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int BOX_W  = (NUM_MAILBOXES > 1) ? $clog2(NUM_MAILBOXES) : 1;
    localparam int PTR_W  = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int PN_W   = PTR_W + 1;
    localparam int CNT_W  = $clog2(MAX_DEPTH + 1);
    localparam int SLOTS  = NUM_MAILBOXES * MAX_DEPTH;
    localparam int ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CAPX_W = CAP_IN_W + 1;
    localparam int IDX_W  = ID_W + 1;

    // Input register
    logic                  s1_valid_reg;
    cmd_t                  s1_cmd_reg;
    logic [ID_W-1:0]       s1_id_reg;
    logic [CAP_IN_W-1:0]   s1_cap_reg;
    logic [WORD_W-1:0]     s1_wd_reg;

    // Result register
    logic                  s2_valid_reg;
    status_t               s2_status_reg;
    logic [ID_W-1:0]       s2_cid_reg;
    logic [OCC_W-1:0]      s2_occ_reg;
    logic                  s2_rd_sel_reg;

    // Mailbox state
    logic [NUM_MAILBOXES-1:0] box_in_use_reg, box_in_use_next;
    logic [CNT_W-1:0]         box_cap_reg   [NUM_MAILBOXES];
    logic [CNT_W-1:0]         box_cap_next  [NUM_MAILBOXES];
    logic [PTR_W-1:0]         rd_ptr_reg    [NUM_MAILBOXES];
    logic [PTR_W-1:0]         rd_ptr_next   [NUM_MAILBOXES];
    logic [PTR_W-1:0]         wr_ptr_reg    [NUM_MAILBOXES];
    logic [PTR_W-1:0]         wr_ptr_next   [NUM_MAILBOXES];
    logic [CNT_W-1:0]         fill_reg      [NUM_MAILBOXES];
    logic [CNT_W-1:0]         fill_next     [NUM_MAILBOXES];

    logic                  s2_ready;
    logic                  s1_fire;
    logic [BOX_W-1:0]      box_idx;
    logic                  id_ok;
    logic [BOX_W-1:0]      free_idx;
    logic                  any_free;
    logic [CNT_W-1:0]      cap_clamped;
    logic [CNT_W-1:0]      cur_cap;
    logic [CNT_W-1:0]      cur_fill;
    logic [PN_W-1:0]       wp_inc;
    logic [PN_W-1:0]       rp_inc;
    logic [PTR_W-1:0]      wp_wrap;
    logic [PTR_W-1:0]      rp_wrap;
    logic [CNT_W+OCC_W-1:0]  occ_wide;
    logic [DATA_WIDTH+WORD_W-1:0] wd_wide;
    logic [DATA_WIDTH+WORD_W-1:0] rd_wide;

    status_t               res_status;
    logic [ID_W-1:0]       res_cid;
    logic [OCC_W-1:0]      res_occ;
    logic                  send_ok;
    logic                  recv_ok;

    logic [ADDR_W-1:0]     box_base;
    logic [ADDR_W-1:0]     wr_addr;
    logic [ADDR_W-1:0]     rd_addr;
    logic [DATA_WIDTH-1:0] ram_rd_data;

    assign s2_ready = !s2_valid_reg || m_tready;
    assign s1_fire  = s1_valid_reg && s2_ready;
    assign s_tready = !s1_valid_reg || s1_fire;

    assign box_idx = s1_id_reg[BOX_W-1:0];
    assign id_ok   = ({1'b0, s1_id_reg} < IDX_W'(NUM_MAILBOXES)) && box_in_use_reg[box_idx];

    // Lowest-numbered free mailbox.
    always_comb
    begin
        free_idx = '0;
        for (int i = NUM_MAILBOXES - 1; i >= 0; i--)
        begin
            if (!box_in_use_reg[i])
            begin
                free_idx = BOX_W'(i);
            end
        end
        any_free = ~&box_in_use_reg;
    end

    assign cap_clamped = ({1'b0, s1_cap_reg} > CAPX_W'(MAX_DEPTH)) ? CNT_W'(MAX_DEPTH)
                                                                   : CNT_W'(s1_cap_reg);

    assign cur_cap  = box_cap_reg[box_idx];
    assign cur_fill = fill_reg[box_idx];
    assign wp_inc   = {1'b0, wr_ptr_reg[box_idx]} + PN_W'(1);
    assign rp_inc   = {1'b0, rd_ptr_reg[box_idx]} + PN_W'(1);
    assign wp_wrap  = (wp_inc >= PN_W'(cur_cap)) ? '0 : wp_inc[PTR_W-1:0];
    assign rp_wrap  = (rp_inc >= PN_W'(cur_cap)) ? '0 : rp_inc[PTR_W-1:0];
    assign occ_wide = {{OCC_W{1'b0}}, cur_fill};
    assign wd_wide  = {{DATA_WIDTH{1'b0}}, s1_wd_reg};

    // Command decode and next mailbox state.
    always_comb
    begin
        box_in_use_next = box_in_use_reg;
        box_cap_next    = box_cap_reg;
        rd_ptr_next     = rd_ptr_reg;
        wr_ptr_next     = wr_ptr_reg;
        fill_next       = fill_reg;
        res_status      = ST_BAD_ID;
        res_cid         = '0;
        res_occ         = '0;
        send_ok         = 1'b0;
        recv_ok         = 1'b0;

        case (s1_cmd_reg)
            CMD_CREATE:
            begin
                if (s1_cap_reg == '0)
                begin
                    res_status = ST_BAD_CAP;
                end
                else if (!any_free)
                begin
                    res_status = ST_NO_BOX;
                end
                else
                begin
                    box_in_use_next[free_idx] = 1'b1;
                    box_cap_next[free_idx]    = cap_clamped;
                    rd_ptr_next[free_idx]     = '0;
                    wr_ptr_next[free_idx]     = '0;
                    fill_next[free_idx]       = '0;
                    res_status                = ST_OK;
                    res_cid                   = ID_W'(free_idx);
                end
            end
            CMD_DESTROY:
            begin
                if (id_ok)
                begin
                    box_in_use_next[box_idx] = 1'b0;
                    res_status               = ST_OK;
                end
            end
            CMD_SEND:
            begin
                if (id_ok)
                begin
                    if (cur_fill >= cur_cap)
                    begin
                        res_status = ST_FULL;
                    end
                    else
                    begin
                        send_ok               = 1'b1;
                        wr_ptr_next[box_idx]  = wp_wrap;
                        fill_next[box_idx]    = cur_fill + CNT_W'(1);
                        res_status            = ST_OK;
                    end
                end
            end
            CMD_RECEIVE:
            begin
                if (id_ok)
                begin
                    if (cur_fill == '0)
                    begin
                        res_status = ST_EMPTY;
                    end
                    else
                    begin
                        recv_ok               = 1'b1;
                        rd_ptr_next[box_idx]  = rp_wrap;
                        fill_next[box_idx]    = cur_fill - CNT_W'(1);
                        res_status            = ST_OK;
                    end
                end
            end
            CMD_COUNT:
            begin
                if (id_ok)
                begin
                    res_occ    = occ_wide[OCC_W-1:0];
                    res_status = ST_OK;
                end
            end
            default:
            begin
                res_status = ST_BAD_ID;
            end
        endcase
    end

    assign box_base = ADDR_W'(box_idx) * ADDR_W'(MAX_DEPTH);
    assign wr_addr  = box_base + ADDR_W'(wr_ptr_reg[box_idx]);
    assign rd_addr  = box_base + ADDR_W'(rd_ptr_reg[box_idx]);

    mmq_slot_ram #(
        .DEPTH  (SLOTS),
        .ADDR_W (ADDR_W),
        .DATA_W (DATA_WIDTH)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (s1_fire && send_ok),
        .wr_addr (wr_addr),
        .wr_data (wd_wide[DATA_WIDTH-1:0]),
        .rd_en   (s1_fire && recv_ok),
        .rd_addr (rd_addr),
        .rd_data (ram_rd_data)
    );

    // Control and mailbox state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            box_in_use_reg <= '0;
            for (int i = 0; i < NUM_MAILBOXES; i++)
            begin
                box_cap_reg[i] <= '0;
                rd_ptr_reg[i]  <= '0;
                wr_ptr_reg[i]  <= '0;
                fill_reg[i]    <= '0;
            end
        end
        else
        begin
            if (s_tready)
            begin
                s1_valid_reg <= s_tvalid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s1_fire)
            begin
                box_in_use_reg <= box_in_use_next;
                box_cap_reg    <= box_cap_next;
                rd_ptr_reg     <= rd_ptr_next;
                wr_ptr_reg     <= wr_ptr_next;
                fill_reg       <= fill_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            s1_cmd_reg <= cmd_t'(s_tdata[2:0]);
            s1_id_reg  <= s_tdata[10:3];
            s1_cap_reg <= s_tdata[20:11];
            s1_wd_reg  <= s_tdata[52:21];
        end
        if (s1_fire)
        begin
            s2_status_reg <= res_status;
            s2_cid_reg    <= res_cid;
            s2_occ_reg    <= res_occ;
            s2_rd_sel_reg <= recv_ok;
        end
    end

    assign rd_wide  = {{WORD_W{1'b0}}, (s2_rd_sel_reg ? ram_rd_data : '0)};
    assign m_tvalid = s2_valid_reg;
    assign m_tdata  = {6'b0, s2_occ_reg, rd_wide[WORD_W-1:0], s2_cid_reg, s2_status_reg};

    // A successful create marks the claimed mailbox as used.
    a_create_claims: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && s1_cmd_reg == CMD_CREATE && res_status == ST_OK
        |=> box_in_use_reg[$past(free_idx)])
        else $error("created mailbox not marked in use");

    // An accepted send raises that mailbox's fill count by exactly one.
    a_send_fill: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && send_ok
        |=> fill_reg[$past(box_idx)] == $past(cur_fill) + CNT_W'(1))
        else $error("send did not advance fill count");

    // Both stages full and the output stalled: no new beat may enter.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s2_valid_reg && !m_tready |-> !s_tready)
        else $error("input accepted while pipeline is blocked");

    // Only a successful receive carries a data word.
    a_rd_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && s2_status_reg != ST_OK |-> m_tdata[42:11] == '0)
        else $error("read data set on a failed command");

endmodule

[sim/tb_top.sv]
// Self-checking testbench for the mailbox queue manager: stream stimulus, prediction and checks.
`timescale 1ns / 1ps

import mmq_pkg::*;

typedef struct {
    status_t               status;
    logic [ID_W-1:0]       created_id;
    logic [WORD_W-1:0]     read_data;
    logic [OCC_W-1:0]      occupancy;
} mailbox_reply_t;

class mailbox_pool_model;
    localparam int BOXES = NUM_MAILBOXES_DEF;
    localparam int SLOTS = MAX_DEPTH_DEF;
    localparam int PTR_W = $clog2(MAX_DEPTH_DEF);

    bit                in_use [BOXES];
    logic [OCC_W-1:0]  depth  [BOXES];
    logic [PTR_W-1:0]  rd_ptr [BOXES];
    logic [PTR_W-1:0]  wr_ptr [BOXES];
    logic [OCC_W-1:0]  fill   [BOXES];
    logic [WORD_W-1:0] slots  [BOXES][SLOTS];
    mailbox_reply_t    pending_replies [$];
    int                mismatches;

    function new();
        for (int i = 0; i < BOXES; i++)
        begin
            in_use[i] = 1'b0;
            depth[i]  = '0;
            rd_ptr[i] = '0;
            wr_ptr[i] = '0;
            fill[i]   = '0;
        end
        mismatches = 0;
    endfunction

    function logic [PTR_W-1:0] ring_advance(logic [PTR_W-1:0] ptr, logic [OCC_W-1:0] size);
        int n;
        n = int'(ptr) + 1;
        return (n >= int'(size)) ? '0 : PTR_W'(n);
    endfunction

    // Random mailbox that currently exists, or any in-range id when none does.
    function int pick_live_box();
        int live [$];
        for (int i = 0; i < BOXES; i++)
            if (in_use[i])
                live.push_back(i);
        if (live.size() == 0)
            return $urandom_range(BOXES - 1);
        return live[$urandom_range(live.size() - 1)];
    endfunction

    // Updates the pool state for one accepted command beat and queues its reply.
    function void apply_command(logic [S_TDATA_W-1:0] beat);
        logic [CMD_W-1:0]    op;
        logic [ID_W-1:0]     id;
        logic [CAP_IN_W-1:0] cap;
        logic [WORD_W-1:0]   wd;
        mailbox_reply_t      r;
        int                  b;
        bit                  live;
        op = beat[2:0];
        id = beat[10:3];
        cap = beat[20:11];
        wd = beat[52:21];
        r.status = ST_BAD_ID;
        r.created_id = '0;
        r.read_data = '0;
        r.occupancy = '0;
        b = int'(id) % BOXES;
        live = (int'(id) < BOXES) && in_use[b];
        if (op == CMD_CREATE)
        begin
            if (cap == 0)
                r.status = ST_BAD_CAP;
            else
            begin
                r.status = ST_NO_BOX;
                for (int i = 0; i < BOXES; i++)
                begin
                    if (!in_use[i])
                    begin
                        in_use[i] = 1'b1;
                        depth[i] = (int'(cap) > SLOTS) ? OCC_W'(SLOTS) : OCC_W'(cap);
                        rd_ptr[i] = '0;
                        wr_ptr[i] = '0;
                        fill[i] = '0;
                        r.status = ST_OK;
                        r.created_id = ID_W'(i);
                        break;
                    end
                end
            end
        end
        else if (live)
        begin
            case (op)
                CMD_DESTROY:
                begin
                    in_use[b] = 1'b0;
                    r.status = ST_OK;
                end
                CMD_SEND:
                begin
                    if (fill[b] >= depth[b])
                        r.status = ST_FULL;
                    else
                    begin
                        slots[b][wr_ptr[b]] = wd;
                        wr_ptr[b] = ring_advance(wr_ptr[b], depth[b]);
                        fill[b] = fill[b] + 1'b1;
                        r.status = ST_OK;
                    end
                end
                CMD_RECEIVE:
                begin
                    if (fill[b] == 0)
                        r.status = ST_EMPTY;
                    else
                    begin
                        r.read_data = slots[b][rd_ptr[b]];
                        rd_ptr[b] = ring_advance(rd_ptr[b], depth[b]);
                        fill[b] = fill[b] - 1'b1;
                        r.status = ST_OK;
                    end
                end
                CMD_COUNT:
                begin
                    r.occupancy = fill[b];
                    r.status = ST_OK;
                end
                default:
                    r.status = ST_BAD_ID;
            endcase
        end
        pending_replies.push_back(r);
    endfunction

    function void compare_reply(logic [M_TDATA_W-1:0] beat);
        mailbox_reply_t want;
        if (pending_replies.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: result beat %h with no command outstanding", $realtime, beat);
            return;
        end
        want = pending_replies.pop_front();
        if (beat[2:0] !== want.status || beat[10:3] !== want.created_id
            || beat[42:11] !== want.read_data || beat[49:43] !== want.occupancy)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: mismatch status %0d/%0d id %0d/%0d data %h/%h occ %0d/%0d (exp/act)",
                         $realtime, want.status, beat[2:0], want.created_id, beat[10:3],
                         want.read_data, beat[42:11], want.occupancy, beat[49:43]);
        end
    endfunction
endclass

module tb_top;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // cmd, mailbox_id, capacity, write_data, zero padding (lowest bit up)
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // status, created_id, read_data, occupancy, zero padding (lowest bit up)
    logic [M_TDATA_W-1:0] m_tdata;

    bit                   steady = 1'b0;
    mailbox_pool_model    pool = new();

    multi_mailbox_queue_manager i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= steady || ($urandom_range(99) >= 23);
    end

    // A result that leaves on the same edge as a new command always belongs to an older one.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                pool.compare_reply(m_tdata);
            if (s_tvalid && s_tready)
                pool.apply_command(s_tdata);
        end
    end

    task automatic drive_beat(input logic [S_TDATA_W-1:0] beat);
        while (!steady && $urandom_range(99) < 23)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= beat;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    task automatic issue(input logic [CMD_W-1:0] op, input int id, input int cap,
                         input logic [WORD_W-1:0] wd);
        drive_beat({3'b000, wd, CAP_IN_W'(cap), ID_W'(id), op});
    endtask

    initial
    begin
        #400000;
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        int                run_sends;
        int                run_recvs;
        int                run_box;
        int                pick;
        int                cap;
        logic [WORD_W-1:0] wd;
        run_sends = 0;
        run_recvs = 0;
        run_box = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Commands on ids that do not exist, and the unused command codes.
        issue(CMD_RECEIVE, 0, 0, '0);
        issue(CMD_COUNT, 255, 1023, '1);
        issue(CMD_SEND, 16, 5, 32'h1234_5678);
        issue(3'd5, 0, 1, 32'hdead_beef);
        issue(3'd6, 3, 2, '1);
        issue(3'd7, 0, 0, '0);
        // Zero capacity, oversize capacity and the smallest mailbox.
        issue(CMD_CREATE, 0, 0, '0);
        issue(CMD_CREATE, 0, 1023, '0);
        issue(CMD_CREATE, 7, 1, '0);
        issue(CMD_SEND, 1, 0, '1);
        issue(CMD_SEND, 1, 0, '0);
        issue(CMD_COUNT, 1, 0, '0);
        issue(CMD_RECEIVE, 1, 0, '0);
        issue(CMD_RECEIVE, 1, 0, '0);
        // Destroyed mailboxes reject everything until claimed again.
        issue(CMD_DESTROY, 1, 0, '0);
        issue(CMD_SEND, 1, 0, 32'h5555_aaaa);
        issue(CMD_DESTROY, 1, 0, '0);
        issue(CMD_CREATE, 0, 64, '0);
        issue(CMD_CREATE, 0, 65, '0);
        issue(CMD_SEND, 0, 0, '0);
        issue(CMD_COUNT, 0, 0, '0);
        issue(CMD_DESTROY, 255, 0, '0);
        issue(CMD_RECEIVE, 0, 0, '0);

        for (int i = 0; i < 1250; i++)
        begin
            steady = (i >= 500 && i < 750);
            wd = $urandom;
            if ($urandom_range(9) == 0)
                wd = $urandom_range(1) ? '1 : '0;
            if (run_sends == 0 && run_recvs == 0 && $urandom_range(99) < 3)
            begin
                // A long fill-then-drain run reaches full mailboxes and pointer wrap.
                run_box = pool.pick_live_box();
                run_sends = $urandom_range(1, 70);
                run_recvs = run_sends;
            end
            if (run_sends > 0)
            begin
                run_sends--;
                issue(CMD_SEND, run_box, $urandom_range(1023), wd);
            end
            else if (run_recvs > 0)
            begin
                run_recvs--;
                issue(CMD_RECEIVE, run_box, $urandom_range(1023), wd);
            end
            else
            begin
                pick = $urandom_range(99);
                if (pick < 12)
                begin
                    cap = $urandom_range(99);
                    if (cap < 5)
                        cap = 0;
                    else if (cap < 70)
                        cap = $urandom_range(1, 8);
                    else if (cap < 85)
                        cap = $urandom_range(9, 64);
                    else
                        cap = $urandom_range(65, 1023);
                    issue(CMD_CREATE, $urandom_range(255), cap, wd);
                end
                else if (pick < 18)
                    issue(CMD_DESTROY, pool.pick_live_box(), $urandom_range(1023), wd);
                else if (pick < 55)
                    issue(CMD_SEND, pool.pick_live_box(), $urandom_range(1023), wd);
                else if (pick < 88)
                    issue(CMD_RECEIVE, pool.pick_live_box(), $urandom_range(1023), wd);
                else if (pick < 94)
                    issue(CMD_COUNT, pool.pick_live_box(), $urandom_range(1023), wd);
                else
                    issue(CMD_W'($urandom), $urandom_range(255), $urandom_range(1023), wd);
            end
        end
        steady = 1'b0;
        s_tvalid <= 1'b0;

        while (pool.pending_replies.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        if (pool.mismatches == 0 && pool.pending_replies.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
